@@ design/esd_pkg.sv @@
// Shared types, character codes and decode helpers for the escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] MaxLenReset = 16'hFFFF;

  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [ByteW-1:0] CharBslash = 8'h5C;
  localparam logic [ByteW-1:0] CharX      = 8'h78;
  localparam logic [ByteW-1:0] CharN      = 8'h6E;
  localparam logic [ByteW-1:0] CharR      = 8'h72;
  localparam logic [ByteW-1:0] CharA      = 8'h61;
  localparam logic [ByteW-1:0] CharT      = 8'h74;
  localparam logic [ByteW-1:0] CharB      = 8'h62;
  localparam logic [ByteW-1:0] CharF      = 8'h66;
  localparam logic [ByteW-1:0] CharV      = 8'h76;
  localparam logic [ByteW-1:0] Char0      = 8'h30;
  localparam logic [ByteW-1:0] Char9      = 8'h39;
  localparam logic [ByteW-1:0] CharUpA    = 8'h41;
  localparam logic [ByteW-1:0] CharUpF    = 8'h46;
  localparam logic [ByteW-1:0] CharLoF    = 8'h66;
  localparam logic [ByteW-1:0] LowerMask  = 8'h20;
  // 'a' - 0xa: maps a lowercase hex letter onto its digit value
  localparam logic [ByteW-1:0] HexAOffset = 8'h57;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_XSEEN,
    MODE_ONEHEX
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              string_done;
    logic [CountW-1:0] byte_count;
    logic              last_in_run;
  } result_t;

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return (c >= Char0 && c <= Char9) || (c >= CharA && c <= CharLoF) ||
           (c >= CharUpA && c <= CharUpF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    v = (c | LowerMask) - HexAOffset;
    if (c <= Char9) begin
      return c[3:0];
    end
    return v[3:0];
  endfunction

  function automatic logic [ByteW-1:0] escape_code(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    unique case (c)
      CharN:   r = 8'h0A;
      CharR:   r = 8'h0D;
      CharA:   r = 8'h07;
      CharT:   r = 8'h09;
      CharB:   r = 8'h08;
      CharF:   r = 8'h0C;
      CharV:   r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/esd_in_if.sv @@
// Source character channel: valid/ready with one byte of payload.
`timescale 1ns / 1ps
`default_nettype none

interface esd_in_if;
  import esd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ design/esd_out_if.sv @@
// Decoded result channel: valid/ready with data byte or end-of-string count.
`timescale 1ns / 1ps
`default_nettype none

interface esd_out_if;
  import esd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic              string_done;
  logic [CountW-1:0] byte_count;
  logic              last_in_run;

  modport source (output valid, output out_byte, output string_done,
                  output byte_count, output last_in_run, input ready);
  modport sink   (input valid, input out_byte, input string_done,
                  input byte_count, input last_in_run, output ready);
endinterface

`default_nettype wire

@@ design/escape_sequence_decoder.sv @@
// Streaming backslash escape decoder: top level.
//
// Usage: source characters arrive on in_i one per transfer; a zero byte ends
// the string. Decoded bytes leave on out_o, one result per transfer. A string
// always ends with a result that has string_done set and carries in
// byte_count how many data bytes were sent for it. last_in_run marks the final
// result caused by one character; a character may cause zero, one or two.
// cfg_we_i/cfg_wdata_i set the per-string output limit (reset 65535); bytes
// past the limit are dropped until the terminator.
// Flow: a character waits in the input register, is decoded into the result
// queue and is then offered on out_o. Throughput: one character per cycle while
// the queue has room; out_o moves one result per cycle while the receiver is
// ready, so two results from one character take two transfers. A 4-entry result
// queue between the decode register and out_o lets in_i keep taking characters
// while a result waits; on a receiver stall it fills and in_i.ready drops.
// Reset clears the decode state, the queue and sets the limit to 65535.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  esd_in_if.sink                    in_i,
  esd_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [esd_pkg::CountW-1:0] cfg_wdata_i
);
  import esd_pkg::*;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned PtrW     = $clog2(ResDepth);
  localparam int unsigned FillW    = $clog2(ResDepth + 1);

  // input register
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;

  // decode state
  mode_e             mode_q, mode_d;
  logic [3:0]        nib_q, nib_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] max_q;

  // result queue
  result_t          res_q [ResDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [FillW-1:0] fill_q;

  logic pop, room, s1_fire;

  // decode helpers
  logic [ByteW-1:0]  c;
  logic              c_hex, c_nul, c_bs;
  logic [3:0]        hv;
  logic              want0, norm;
  logic [ByteW-1:0]  b0;
  logic              ok0, ok1, done1, sec;
  logic [CountW-1:0] cnt1, cnt2;

  result_t    res_a, res_b;
  logic [1:0] push_n;

  assign pop     = out_o.valid && out_o.ready;
  assign room    = (fill_q <= FillW'(ResDepth - 2)) ||
                   (pop && (fill_q <= FillW'(ResDepth - 1)));
  assign s1_fire = s1_valid_q && room;

  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign c     = s1_byte_q;
  assign c_hex = is_hex(c);
  assign c_nul = (c == CharNul);
  assign c_bs  = (c == CharBslash);
  assign hv    = hex_value(c);

  // want0/b0: byte the escape state itself produces; norm: the character is
  // then handled as plain text (or as terminator)
  always_comb begin
    want0 = 1'b0;
    b0    = c;
    norm  = 1'b0;
    unique case (mode_q)
      MODE_NORMAL: begin
        norm = 1'b1;
      end
      MODE_ESCAPE: begin
        want0 = !c_nul && (c != CharX);
        b0    = escape_code(c);
        norm  = c_nul;
      end
      MODE_XSEEN: begin
        want0 = !c_hex;
        b0    = CharX;
        norm  = !c_hex;
      end
      MODE_ONEHEX: begin
        want0 = 1'b1;
        b0    = c_hex ? {nib_q, hv} : {4'h0, nib_q};
        norm  = !c_hex;
      end
      default: begin
        norm = 1'b1;
      end
    endcase
  end

  assign ok0   = want0 && (count_q < max_q);
  assign cnt1  = count_q + CountW'(ok0);
  assign done1 = norm && c_nul;
  assign ok1   = norm && !c_nul && !c_bs && (cnt1 < max_q);
  assign cnt2  = cnt1 + CountW'(ok1);
  assign sec   = ok1 || done1;

  // next state
  always_comb begin
    mode_d  = MODE_NORMAL;
    nib_d   = nib_q;
    count_d = cnt2;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (c_bs) begin
          mode_d = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        if (c == CharX) begin
          mode_d = MODE_XSEEN;
        end
      end
      MODE_XSEEN: begin
        if (c_hex) begin
          mode_d = MODE_ONEHEX;
          nib_d  = hv;
        end else if (c_bs) begin
          mode_d = MODE_ESCAPE;
        end
      end
      MODE_ONEHEX: begin
        nib_d = 4'h0;
        if (!c_hex && c_bs) begin
          mode_d = MODE_ESCAPE;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase
    if (done1) begin
      mode_d  = MODE_NORMAL;
      nib_d   = 4'h0;
      count_d = '0;
    end
  end

  // results to queue
  always_comb begin
    result_t r_first, r_sec;
    r_first.out_byte    = b0;
    r_first.string_done = 1'b0;
    r_first.byte_count  = '0;
    r_first.last_in_run = !sec;
    r_sec.out_byte      = done1 ? CharNul : c;
    r_sec.string_done   = done1;
    r_sec.byte_count    = done1 ? cnt1 : '0;
    r_sec.last_in_run   = 1'b1;
    if (ok0) begin
      res_a  = r_first;
      res_b  = r_sec;
      push_n = 2'd1 + 2'(sec);
    end else begin
      res_a  = r_sec;
      res_b  = r_sec;
      push_n = 2'(sec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      nib_q   <= 4'h0;
      count_q <= '0;
    end else if (s1_fire) begin
      mode_q  <= mode_d;
      nib_q   <= nib_d;
      count_q <= count_d;
    end
  end

  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (s1_fire && push_n != 2'd0) begin
      res_q[wr_ptr_q] <= res_a;
    end
    if (s1_fire && push_n == 2'd2) begin
      res_q[wr_ptr_nxt] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (s1_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q - FillW'(pop) + (s1_fire ? FillW'(push_n) : FillW'(0));
    end
  end

  assign out_o.valid       = (fill_q != '0);
  assign out_o.out_byte    = res_q[rd_ptr_q].out_byte;
  assign out_o.string_done = res_q[rd_ptr_q].string_done;
  assign out_o.byte_count  = res_q[rd_ptr_q].byte_count;
  assign out_o.last_in_run = res_q[rd_ptr_q].last_in_run;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(ResDepth))
    else $error("result queue overfilled");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && done1 |=> mode_q == MODE_NORMAL && count_q == '0 && nib_q == 4'h0)
    else $error("decode state not cleared after string end");

  a_data_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.string_done |-> out_o.byte_count == '0)
    else $error("data result carries a byte count");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_byte_q))
    else $error("stalled input register lost its character");

endmodule

`default_nettype wire
